// ----- rtl/addressable_led_frame_encoder_defines.svh -----
// assertion macros for the led frame encoder checker
`ifndef ADDRESSABLE_LED_FRAME_ENCODER_DEFINES_SVH
`define ADDRESSABLE_LED_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication, masked during reset
`define ALED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define ALED_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/aled_pkg.sv -----
package aled_pkg;

  // pwm timer period and the two duty codes derived from it
  localparam int TIMER_PERIOD = 176 + 4;
  localparam logic [7:0] DUTY_ONE  = 8'(TIMER_PERIOD / 2);
  localparam logic [7:0] DUTY_ZERO = 8'(TIMER_PERIOD / 4);

  // leds below this index come from the internal store in automatic mode
  localparam int SYSTEM_SLOTS  = 4;
  localparam int BYTES_PER_LED = 3;
  localparam int CMDQ_DEPTH    = 2;

  // configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_AUTO_MODE  = 2'd1;

  localparam logic [7:0] BRIGHTNESS_RESET = 8'hFF;
  localparam logic       AUTO_MODE_RESET  = 1'b1;

  typedef enum logic {
    CMD_WRITE,
    CMD_SEND
  } cmd_kind_t;

  // one classified command, color already in green, red, blue order
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  slot;
    logic [23:0] grb;
    logic        internal_target;
  } cmd_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       automatic_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_BYTES,
    SEQ_GAP
  } seq_state_t;

  // floor(p / 255) for any p up to 255*255, the product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = 17'(p) + 17'd1 + 17'(p[15:8]);
    return t[15:8];
  endfunction

  // msb first, first sent bit in the top byte
  function automatic logic [63:0] expand_byte(input logic [7:0] v);
    logic [63:0] codes;
    for (int k = 0; k < 8; k++) begin
      codes[63 - 8*k -: 8] = v[7 - k] ? DUTY_ONE : DUTY_ZERO;
    end
    return codes;
  endfunction

endpackage

// ----- rtl/aled_front.sv -----
module aled_front #(
  parameter int LED_COUNT = 6
) (
  input  logic          start,
  input  logic          mode,
  input  logic [2:0]    led_slot,
  input  logic [23:0]   color,
  input  logic          internal_target,
  input  logic          q_full,
  output logic          busy,
  output logic          push,
  output aled_pkg::cmd_t cmd
);
  import aled_pkg::*;

  logic slot_ok;

  // writes to slots past the chain are dropped here
  assign slot_ok = (32'(led_slot) < LED_COUNT);
  assign busy    = q_full;
  assign push    = start && !q_full && (mode || slot_ok);

  // classify the beat and reorder the color bytes
  always_comb begin
    cmd.kind            = mode ? CMD_SEND : CMD_WRITE;
    cmd.slot            = led_slot;
    cmd.grb             = {color[15:8], color[23:16], color[7:0]};
    cmd.internal_target = internal_target;
  end

endmodule

// ----- rtl/aled_cmdq.sv -----
module aled_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aled_pkg::cmd_t push_cmd,
  input  logic           pop,
  output aled_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import aled_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entries [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(CMDQ_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/aled_back.sv -----
module aled_back #(
  parameter int LED_COUNT = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  aled_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  aled_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           result_strobe,
  output logic [4:0]     byte_position,
  output logic [7:0]     scaled_value,
  output logic [63:0]    duty_codes,
  output logic           reset_gap,
  output logic           last
);
  import aled_pkg::*;

  localparam int FRAME_BYTES = LED_COUNT * BYTES_PER_LED;
  localparam int LED_W       = $clog2(LED_COUNT);
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  seq_state_t state;
  seq_state_t state_next;

  logic [LED_W-1:0] led_idx;
  logic [1:0]       byte_sel;
  logic [POS_W-1:0] pos;

  logic             load;
  logic             issue_byte;
  logic             issue_gap;
  logic             we_int;
  logic             we_usr;
  logic [LED_W-1:0] wr_idx;

  // color stores, one 24-bit row per led, valid bit per row
  logic [23:0]          int_mem [LED_COUNT];
  logic [23:0]          usr_mem [LED_COUNT];
  logic [LED_COUNT-1:0] int_vld;
  logic [LED_COUNT-1:0] usr_vld;
  logic [23:0]          int_row;
  logic [23:0]          usr_row;
  logic                 int_ok;
  logic                 usr_ok;

  logic             s1_valid;
  logic             s1_gap;
  logic [POS_W-1:0] s1_pos;
  logic [1:0]       s1_sel;
  logic             s1_int;

  logic [23:0]      pick_row;
  logic [7:0]       pick_byte;

  logic             s2_valid;
  logic             s2_gap;
  logic [POS_W-1:0] s2_pos;
  logic [15:0]      s2_prod;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (!q_empty && q_cmd.kind == CMD_SEND) begin
          state_next = SEQ_BYTES;
        end
      end
      SEQ_BYTES: begin
        if (pos == LAST_POS) begin
          state_next = SEQ_GAP;
        end
      end
      SEQ_GAP: begin
        state_next = SEQ_IDLE;
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    issue_byte = 1'b0;
    issue_gap  = 1'b0;
    we_int     = 1'b0;
    we_usr     = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        q_pop  = !q_empty;
        load   = !q_empty && q_cmd.kind == CMD_SEND;
        we_int = !q_empty && q_cmd.kind == CMD_WRITE && q_cmd.internal_target;
        we_usr = !q_empty && q_cmd.kind == CMD_WRITE && !q_cmd.internal_target;
      end
      SEQ_BYTES: begin
        issue_byte = 1'b1;
      end
      SEQ_GAP: begin
        issue_gap = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      led_idx  <= '0;
      byte_sel <= '0;
      pos      <= '0;
    end else if (load) begin
      led_idx  <= '0;
      byte_sel <= '0;
      pos      <= '0;
    end else if (issue_byte) begin
      pos <= pos + 1'b1;
      if (byte_sel == 2'(BYTES_PER_LED - 1)) begin
        byte_sel <= '0;
        led_idx  <= led_idx + 1'b1;
      end else begin
        byte_sel <= byte_sel + 1'b1;
      end
    end
  end

  assign wr_idx = LED_W'(q_cmd.slot);

  // store writes and registered row reads
  always_ff @(posedge clk) begin
    if (we_int) begin
      int_mem[wr_idx] <= q_cmd.grb;
    end
    if (we_usr) begin
      usr_mem[wr_idx] <= q_cmd.grb;
    end
    if (issue_byte) begin
      int_row <= int_mem[led_idx];
      usr_row <= usr_mem[led_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_vld <= '0;
      usr_vld <= '0;
      int_ok  <= 1'b0;
      usr_ok  <= 1'b0;
    end else begin
      if (we_int) begin
        int_vld[wr_idx] <= 1'b1;
      end
      if (we_usr) begin
        usr_vld[wr_idx] <= 1'b1;
      end
      if (issue_byte) begin
        int_ok <= int_vld[led_idx];
        usr_ok <= usr_vld[led_idx];
      end
    end
  end

  // stage 1 tag, aligned with the row read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue_byte || issue_gap;
    end
  end

  always_ff @(posedge clk) begin
    s1_gap <= issue_gap;
    s1_pos <= pos;
    s1_sel <= byte_sel;
    s1_int <= cfg.automatic_mode && (32'(led_idx) < SYSTEM_SLOTS);
  end

  // pick the store and the byte within the row, zero for the gap beat
  always_comb begin
    if (s1_int) begin
      pick_row = int_ok ? int_row : '0;
    end else begin
      pick_row = usr_ok ? usr_row : '0;
    end
    case (s1_sel)
      2'd0:    pick_byte = pick_row[23:16];
      2'd1:    pick_byte = pick_row[15:8];
      default: pick_byte = pick_row[7:0];
    endcase
    if (s1_gap) begin
      pick_byte = '0;
    end
  end

  // stage 2 brightness product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_gap  <= s1_gap;
    s2_pos  <= s1_pos;
    s2_prod <= 16'(pick_byte) * 16'(cfg.brightness);
  end

  // stage 3 scale, expand and present the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    reset_gap <= s2_gap;
    last      <= s2_gap;
    if (s2_gap) begin
      byte_position <= 5'(FRAME_BYTES);
      scaled_value  <= '0;
      duty_codes    <= '0;
    end else begin
      byte_position <= 5'(s2_pos);
      scaled_value  <= div255(s2_prod);
      duty_codes    <= expand_byte(div255(s2_prod));
    end
  end

endmodule

// ----- rtl/addressable_led_frame_encoder.sv -----
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// command   | start / busy         | mode, led_slot, color, internal_target
// config    | cfg_we               | cfg_index, cfg_data
// result    | result_strobe        | byte_position, scaled_value, duty_codes,
//           |                      | reset_gap, last
//
// a command beat is taken when start is high and busy is low; busy means the
// two-entry command queue is full. a write is queued and lands in its store
// when the sequencer, while idle, takes it from the queue.
// a transmit occupies the sequencer through its byte and gap states and puts
// out LED_COUNT*3 + 1 result beats on consecutive cycles; the command passes
// through the queue and the sequencer, then the row read, brightness multiply
// and scale/expand stages, before the first beat appears.
// rst is synchronous; it clears the queue, sequencer, config and valid bits only.
// results are shown for one cycle each and cannot be held off.
module addressable_led_frame_encoder #(
  parameter int LED_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [2:0]  led_slot,
  input  logic [23:0] color,
  input  logic        internal_target,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        result_strobe,
  output logic [4:0]  byte_position,
  output logic [7:0]  scaled_value,
  output logic [63:0] duty_codes,
  output logic        reset_gap,
  output logic        last
);
  import aled_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness     <= BRIGHTNESS_RESET;
      cfg.automatic_mode <= AUTO_MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: cfg.brightness     <= cfg_data;
        REG_AUTO_MODE:  cfg.automatic_mode <= cfg_data[0];
        default:        cfg.brightness     <= cfg.brightness;
      endcase
    end
  end

  aled_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .start           (start),
    .mode            (mode),
    .led_slot        (led_slot),
    .color           (color),
    .internal_target (internal_target),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .cmd             (push_cmd)
  );

  aled_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  aled_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_cmd         (head),
    .q_pop         (pop),
    .result_strobe (result_strobe),
    .byte_position (byte_position),
    .scaled_value  (scaled_value),
    .duty_codes    (duty_codes),
    .reset_gap     (reset_gap),
    .last          (last)
  );

endmodule

// ----- rtl/aled_checker.sv -----
`include "addressable_led_frame_encoder_defines.svh"

module aled_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_strobe,
  input logic [7:0]  scaled_value,
  input logic [63:0] duty_codes,
  input logic        reset_gap,
  input logic        last
);
  import aled_pkg::*;

  // no result beat right after a reset cycle
  `ALED_ASSERT_NEXT(a_quiet_after_reset, clk, rst, !result_strobe, "result beat after reset")

  // the frame ends on the gap beat
  `ALED_ASSERT_IMP(a_last_is_gap, clk, rst, result_strobe && last, reset_gap, "last without gap")

  // the line stays low through the gap
  `ALED_ASSERT_IMP(a_gap_zero, clk, rst, result_strobe && reset_gap,
    scaled_value == 8'd0 && duty_codes == 64'd0, "gap beat carries data")

  // first duty code follows the msb of the scaled byte
  `ALED_ASSERT_IMP(a_msb_code, clk, rst, result_strobe && !reset_gap,
    duty_codes[63:56] == (scaled_value[7] ? DUTY_ONE : DUTY_ZERO), "msb duty code mismatch")

endmodule

bind addressable_led_frame_encoder aled_checker u_aled_checker (
  .clk           (clk),
  .rst           (rst),
  .result_strobe (result_strobe),
  .scaled_value  (scaled_value),
  .duty_codes    (duty_codes),
  .reset_gap     (reset_gap),
  .last          (last)
);
